[hw/rtl/assert_macros.svh]
// Assertion macros for the RTL files; included by utf16_stream_decoder.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/utf16d_pkg.sv]
// Shared types and constants of the UTF-16 stream decoder.
// No dependencies; used by every module of the decoder.
package utf16d_pkg;

	// Result kinds.
	localparam logic KIND_VALUE  = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	// Error codes, ordered by severity.
	localparam logic [1:0] ERR_NONE    = 2'd0;
	localparam logic [1:0] ERR_UNTRANS = 2'd2;
	localparam logic [1:0] ERR_INVALID = 2'd3;

	// Configuration register indexes.
	localparam logic [1:0] REG_OUTPUT_FORMAT = 2'd0;
	localparam logic [1:0] REG_EMIT_BOM      = 2'd1;
	localparam logic [1:0] REG_ABORT_LEVEL   = 2'd2;

	// Upper six bits that tag high and low surrogates.
	localparam logic [5:0] HIGH_SURR_TAG = 6'b110110;
	localparam logic [5:0] LOW_SURR_TAG  = 6'b110111;

	// Special output values and the supplementary plane offset.
	localparam logic [20:0] BOM_VALUE   = 21'h00FEFF;
	localparam logic [20:0] REPL_VALUE  = 21'h00FFFD;
	localparam logic [20:0] SUPP_OFFSET = 21'h010000;

	// Most results one word can cause.
	localparam int unsigned MAX_RES = 3;

	typedef struct packed {
		logic        output_format;
		logic        emit_bom;
		logic [1:0]  abort_level;
	} cfg_t;

	typedef struct packed {
		logic        kind;
		logic [20:0] char_value;
		logic [1:0]  worst_status;
		logic        aborted;
	} res_t;

	// All results caused by one input word.
	typedef struct packed {
		res_t [MAX_RES-1:0] res;
		logic [1:0]         cnt;
	} bundle_t;

	function automatic res_t mk_value(input logic [20:0] v);
		res_t r;
		r.kind         = KIND_VALUE;
		r.char_value   = v;
		r.worst_status = ERR_NONE;
		r.aborted      = 1'b0;
		return r;
	endfunction

	function automatic res_t mk_status(input logic [1:0] ws, input logic ab);
		res_t r;
		r.kind         = KIND_STATUS;
		r.char_value   = '0;
		r.worst_status = ws;
		r.aborted      = ab;
		return r;
	endfunction

endpackage

[hw/rtl/utf16d_core.sv]
// Decoder state and the single-pass decode of one input word into its results.
// Depends on utf16d_pkg.
module utf16d_core (
	input  logic               clk,
	input  logic               arst_n,
	input  utf16d_pkg::cfg_t   cfg,
	input  logic               in_fire,
	input  logic [15:0]        code_unit,
	input  logic               final_unit,
	output utf16d_pkg::bundle_t bundle
);
	import utf16d_pkg::*;

	logic [9:0] high_bits_q;
	logic       high_pending_q;
	logic       started_q;
	logic [1:0] worst_error_q;
	logic       halted_q;

	logic [9:0] high_bits_d;
	logic       high_pending_d;
	logic       started_d;
	logic [1:0] worst_error_d;
	logic       halted_d;

	logic is_high;
	logic is_low;

	assign is_high = (code_unit[15:10] == HIGH_SURR_TAG);
	assign is_low  = (code_unit[15:10] == LOW_SURR_TAG);

	// Decode the word against the held state and collect its results in order.
	always_comb begin
		logic stop;
		logic fresh;
		bundle         = '0;
		high_bits_d    = high_bits_q;
		high_pending_d = high_pending_q;
		started_d      = started_q;
		worst_error_d  = worst_error_q;
		halted_d       = halted_q;
		stop           = 1'b0;
		fresh          = 1'b1;
		if (!halted_q) begin
			// Byte order mark, if output_format and emit_bom are set, on the first word of a stream.
			if (!started_q) begin
				started_d = 1'b1;
				if (cfg.output_format && cfg.emit_bom) begin
					bundle.res[bundle.cnt] = mk_value(BOM_VALUE);
					bundle.cnt             = bundle.cnt + 2'd1;
				end
			end
			// Complete or break a held high surrogate.
			if (high_pending_q) begin
				high_pending_d = 1'b0;
				if (is_low) begin
					fresh = 1'b0;
					if (cfg.output_format) begin
						if (ERR_UNTRANS > worst_error_d)
							worst_error_d = ERR_UNTRANS;
						if (worst_error_d >= cfg.abort_level) begin
							stop = 1'b1;
						end else begin
							bundle.res[bundle.cnt] = mk_value(REPL_VALUE);
							bundle.cnt             = bundle.cnt + 2'd1;
						end
					end else begin
						bundle.res[bundle.cnt] =
							mk_value(SUPP_OFFSET + {1'b0, high_bits_q, code_unit[9:0]});
						bundle.cnt = bundle.cnt + 2'd1;
					end
				end else begin
					worst_error_d = ERR_INVALID;
					if (worst_error_d >= cfg.abort_level) begin
						stop  = 1'b1;
						fresh = 1'b0;
					end
				end
			end
			// Handle the word on its own.
			if (fresh && !stop) begin
				if (is_high) begin
					high_bits_d    = code_unit[9:0];
					high_pending_d = 1'b1;
				end else if (is_low) begin
					worst_error_d = ERR_INVALID;
					if (worst_error_d >= cfg.abort_level)
						stop = 1'b1;
				end else begin
					bundle.res[bundle.cnt] = mk_value({5'd0, code_unit});
					bundle.cnt             = bundle.cnt + 2'd1;
				end
			end
			// Abort or end-of-stream status.
			if (stop) begin
				bundle.res[bundle.cnt] = mk_status(worst_error_d, 1'b1);
				bundle.cnt             = bundle.cnt + 2'd1;
				halted_d               = 1'b1;
				high_pending_d         = 1'b0;
			end else if (final_unit) begin
				bundle.res[bundle.cnt] = mk_status(worst_error_d, 1'b0);
				bundle.cnt             = bundle.cnt + 2'd1;
				high_pending_d         = 1'b0;
				high_bits_d            = '0;
				started_d              = 1'b0;
				worst_error_d          = ERR_NONE;
			end
		end
	end

	// Stream state advances on each accepted word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_bits_q    <= '0;
			high_pending_q <= 1'b0;
			started_q      <= 1'b0;
			worst_error_q  <= ERR_NONE;
			halted_q       <= 1'b0;
		end else if (in_fire) begin
			high_bits_q    <= high_bits_d;
			high_pending_q <= high_pending_d;
			started_q      <= started_d;
			worst_error_q  <= worst_error_d;
			halted_q       <= halted_d;
		end
	end

endmodule

[hw/rtl/utf16d_outq.sv]
// Result register that holds one word's results and hands them out one per cycle while out_ready is high.
// Depends on utf16d_pkg.
module utf16d_outq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_fire,
	input  utf16d_pkg::bundle_t bundle,
	output logic                load_ok,
	output logic                out_valid,
	input  logic                out_ready,
	output utf16d_pkg::res_t    res,
	output logic                last_res
);
	import utf16d_pkg::*;

	res_t [MAX_RES-1:0] res_s1;
	logic [1:0]         cnt_s1;
	logic [1:0]         idx_q;
	logic               take;

	assign out_valid = (cnt_s1 != 2'd0);
	assign res       = res_s1[idx_q];
	assign last_res  = (idx_q == cnt_s1 - 2'd1);
	assign take      = out_valid && out_ready;
	// A new word may enter when the register is empty or its final result leaves now.
	assign load_ok   = !out_valid || (take && last_res);

	// Payload of the held results.
	always_ff @(posedge clk) begin
		if (in_fire)
			res_s1 <= bundle.res;
	end

	// Count and position of the held results.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_s1 <= 2'd0;
			idx_q  <= 2'd0;
		end else if (in_fire) begin
			cnt_s1 <= bundle.cnt;
			idx_q  <= 2'd0;
		end else if (take) begin
			if (last_res) begin
				cnt_s1 <= 2'd0;
				idx_q  <= 2'd0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

endmodule

[hw/rtl/utf16_stream_decoder.sv]
// Top level of the UTF-16 stream decoder: configuration registers and wiring.
// Depends on utf16d_pkg, utf16d_core, utf16d_outq and assert_macros.svh.
//
//   channel | signals                                    | direction
//   --------+--------------------------------------------+----------
//   in      | in_valid/in_ready, code_unit, final_unit   | sink
//   out     | out_valid/out_ready, kind, char_value,     | source
//           | worst_status, aborted, end_of_run          |
//   cfg     | cfg_valid/cfg_ready, cfg_index, cfg_data   | sink
//
// A word is decoded in the cycle it is accepted and its results (zero to three)
// sit in one result register, shown one per cycle while out_ready is high, from the next cycle on.
// A word that causes at most one result sustains one word per cycle while out_ready is high;
// a word with more results holds the input until the single output port has taken them all.
// Reset clears stream state and the result count and sets the configuration to its defaults.
// Any held result keeps the input off; the next word enters at the edge where the
// last held result is taken, so a stalled output stalls the input.
`include "assert_macros.svh"

module utf16_stream_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] code_unit,
	input  logic        final_unit,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        kind,
	output logic [20:0] char_value,
	output logic [1:0]  worst_status,
	output logic        aborted,
	output logic        end_of_run,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [1:0]  cfg_data
);
	import utf16d_pkg::*;

	cfg_t    cfg_q;
	bundle_t bundle;
	res_t    res;
	logic    in_fire;
	logic    last_res;

	assign cfg_ready = 1'b1;
	assign in_fire   = in_valid && in_ready;

	// Configuration registers; writes to unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.output_format <= 1'b0;
			cfg_q.emit_bom      <= 1'b0;
			cfg_q.abort_level   <= ERR_INVALID;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_OUTPUT_FORMAT: cfg_q.output_format <= cfg_data[0];
				REG_EMIT_BOM:      cfg_q.emit_bom      <= cfg_data[0];
				REG_ABORT_LEVEL:   cfg_q.abort_level   <= cfg_data;
				default: ;
			endcase
		end
	end

	utf16d_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_fire    (in_fire),
		.code_unit  (code_unit),
		.final_unit (final_unit),
		.bundle     (bundle)
	);

	utf16d_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_fire   (in_fire),
		.bundle    (bundle),
		.load_ok   (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res       (res),
		.last_res  (last_res)
	);

	// Result word fields.
	assign kind         = res.kind;
	assign char_value   = res.char_value;
	assign worst_status = res.worst_status;
	assign aborted      = res.aborted;
	assign end_of_run   = last_res;

	// A status word always closes the results of its input word.
	`ASSERT_IMPLIES(a_status_last, out_valid && kind == KIND_STATUS, end_of_run, "status word not last")
	// No new word enters while earlier results of a word are still queued.
	`ASSERT_IMPLIES(a_no_overrun, out_valid && !end_of_run, !in_ready, "input accepted over pending results")
	// Value words carry no status.
	`ASSERT_IMPLIES(a_value_clean, out_valid && kind == KIND_VALUE, worst_status == ERR_NONE && !aborted, "value word with status bits")
	// After an abort is delivered, the decoder stays silent.
	`ASSERT_NEXT(a_halt_silent, out_valid && out_ready && aborted, !out_valid, "output after abort")

endmodule
